### design/aenv_pkg.sv
package aenv_pkg;

   localparam int SAMPLE_WIDTH_DEF    = 24;
   localparam int COEFF_FRAC_BITS_DEF = 24;

   localparam int THR_W   = 24;
   localparam int COEFF_W = 25;
   localparam int ENV_W   = 23;
   localparam int PHASE_W = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [ENV_W-1:0] ENV_ONE   = ENV_W'(4194304);
   localparam logic [ENV_W-1:0] ENV_CLOSE = ENV_W'(41943);
   localparam logic [ENV_W-1:0] ENV_HIGH  = ENV_W'(4194304 - 41943);

   localparam logic [THR_W-1:0]   EDGE_THRESHOLD_RST = THR_W'(2097152);
   localparam logic [COEFF_W-1:0] ATK_GAIN_RST       = COEFF_W'(167772);
   localparam logic [COEFF_W-1:0] DCY_GAIN_RST       = COEFF_W'(167772);
   localparam logic [COEFF_W-1:0] REL_GAIN_RST       = COEFF_W'(16777);
   localparam logic [ENV_W-1:0]   SUS_LEVEL_RST      = ENV_W'(2768241);

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE    = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EDGE_THRESHOLD = 3'd0,
      CSR_ATK_GAIN       = 3'd1,
      CSR_DCY_GAIN       = 3'd2,
      CSR_REL_GAIN       = 3'd3,
      CSR_SUS_LEVEL      = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [THR_W-1:0]   edge_threshold;
      logic [COEFF_W-1:0] atk_gain;
      logic [COEFF_W-1:0] dcy_gain;
      logic [COEFF_W-1:0] rel_gain;
      logic [ENV_W-1:0]   sus_level;
   } cfg_type;

endpackage

### design/aenv_if.sv
interface aenv_req_if #(
   parameter int SAMPLE_WIDTH = aenv_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface aenv_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [aenv_pkg::ENV_W-1:0]   envelope;
   logic [aenv_pkg::PHASE_W-1:0] phase;

   modport source (output valid, output envelope, output phase, input ready);
   modport sink   (input valid, input envelope, input phase, output ready);
endinterface

### design/aenv_csr.sv
module aenv_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [aenv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aenv_pkg::CSR_DATA_W-1:0] csr_wdata,
   output aenv_pkg::cfg_type               cfg
);

   aenv_pkg::cfg_type cfg_ff;
   aenv_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (aenv_pkg::csr_idx_type'(csr_index))
            aenv_pkg::CSR_EDGE_THRESHOLD:
               cfg_in.edge_threshold = csr_wdata[aenv_pkg::THR_W-1:0];
            aenv_pkg::CSR_ATK_GAIN:
               cfg_in.atk_gain = csr_wdata[aenv_pkg::COEFF_W-1:0];
            aenv_pkg::CSR_DCY_GAIN:
               cfg_in.dcy_gain = csr_wdata[aenv_pkg::COEFF_W-1:0];
            aenv_pkg::CSR_REL_GAIN:
               cfg_in.rel_gain = csr_wdata[aenv_pkg::COEFF_W-1:0];
            aenv_pkg::CSR_SUS_LEVEL:
               cfg_in.sus_level = csr_wdata[aenv_pkg::ENV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.edge_threshold <= aenv_pkg::EDGE_THRESHOLD_RST;
         cfg_ff.atk_gain       <= aenv_pkg::ATK_GAIN_RST;
         cfg_ff.dcy_gain       <= aenv_pkg::DCY_GAIN_RST;
         cfg_ff.rel_gain       <= aenv_pkg::REL_GAIN_RST;
         cfg_ff.sus_level      <= aenv_pkg::SUS_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/aenv_step.sv
module aenv_step #(
   parameter int SAMPLE_WIDTH    = aenv_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEFF_FRAC_BITS = aenv_pkg::COEFF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  aenv_pkg::cfg_type              cfg,
   output logic [aenv_pkg::ENV_W-1:0]     env_new,
   output aenv_pkg::phase_type            phase_new
);

   localparam int ENV_W   = aenv_pkg::ENV_W;
   localparam int WIDE_W  = (SAMPLE_WIDTH + 1 > aenv_pkg::THR_W + 1) ?
                            SAMPLE_WIDTH + 1 : aenv_pkg::THR_W + 1;
   localparam int DIFF_W  = WIDE_W + 1;
   localparam int ERR_W   = ENV_W + 1;
   localparam int PROD_W  = aenv_pkg::COEFF_W + 1 + ERR_W;
   localparam int SUM_W   = PROD_W + 1;

   logic signed [SAMPLE_WIDTH-1:0] prev_ff;
   logic [ENV_W-1:0]               env_ff;
   logic [ENV_W-1:0]               target_ff;
   aenv_pkg::phase_type            phase_ff;

   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  thr_x;
   logic                      rise;
   logic                      fall;
   logic signed [ERR_W-1:0]   sus_dist;
   logic [ERR_W-1:0]          sus_abs;
   logic                      near_top;
   logic                      near_sus;
   aenv_pkg::phase_type       edge_phase;
   logic [ENV_W-1:0]          edge_target;
   logic [ENV_W-1:0]          target_in;
   logic [aenv_pkg::COEFF_W-1:0] coeff;
   logic signed [ERR_W-1:0]   err;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  delta;
   logic signed [SUM_W-1:0]   sum;

   // edge detect and level compares
   always_comb begin
      diff     = DIFF_W'(sample) - DIFF_W'(prev_ff);
      thr_x    = DIFF_W'({1'b0, cfg.edge_threshold});
      rise     = diff > thr_x;
      fall     = (-diff) > thr_x;
      sus_dist = $signed({1'b0, env_ff}) - $signed({1'b0, cfg.sus_level});
      sus_abs  = sus_dist[ERR_W-1] ? ERR_W'(-sus_dist) : ERR_W'(sus_dist);
      near_top = env_ff > aenv_pkg::ENV_HIGH;
      near_sus = sus_abs < ERR_W'(aenv_pkg::ENV_CLOSE);
   end

   // next phase and target
   always_comb begin
      edge_phase  = phase_ff;
      edge_target = target_ff;
      if (rise) begin
         edge_phase  = aenv_pkg::PH_ATTACK;
         edge_target = aenv_pkg::ENV_ONE;
      end else if (fall) begin
         edge_phase  = aenv_pkg::PH_RELEASE;
         edge_target = '0;
      end
      phase_new = edge_phase;
      target_in = edge_target;
      if (edge_phase == aenv_pkg::PH_ATTACK && near_top) begin
         phase_new = aenv_pkg::PH_DECAY;
         target_in = cfg.sus_level;
      end else if (edge_phase == aenv_pkg::PH_DECAY && near_sus) begin
         phase_new = aenv_pkg::PH_SUSTAIN;
      end
   end

   // one-pole update with clamp
   always_comb begin
      unique case (phase_new)
         aenv_pkg::PH_ATTACK:  coeff = cfg.atk_gain;
         aenv_pkg::PH_DECAY,
         aenv_pkg::PH_SUSTAIN: coeff = cfg.dcy_gain;
         default:              coeff = cfg.rel_gain;
      endcase
      err   = $signed({1'b0, target_in}) - $signed({1'b0, env_ff});
      prod  = PROD_W'($signed({1'b0, coeff})) * PROD_W'(err);
      delta = prod >>> COEFF_FRAC_BITS;
      sum   = SUM_W'(delta) + SUM_W'($signed({1'b0, env_ff}));
      if (sum < 0) begin
         env_new = '0;
      end else if (sum > SUM_W'($signed({1'b0, aenv_pkg::ENV_ONE}))) begin
         env_new = aenv_pkg::ENV_ONE;
      end else begin
         env_new = sum[ENV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         env_ff    <= '0;
         target_ff <= '0;
         phase_ff  <= aenv_pkg::PH_IDLE;
      end else if (step_en) begin
         prev_ff   <= sample;
         env_ff    <= env_new;
         target_ff <= target_in;
         phase_ff  <= phase_new;
      end
   end

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      env_ff <= aenv_pkg::ENV_ONE)
      else $error("envelope state above one");

   a_no_return_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != aenv_pkg::PH_IDLE |=> phase_ff != aenv_pkg::PH_IDLE)
      else $error("phase went back to idle");

   a_hold_when_off: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(env_ff) && $stable(phase_ff) && $stable(prev_ff))
      else $error("state changed without a step");

   a_attack_target: assert property (@(posedge clock) disable iff (reset)
      phase_ff == aenv_pkg::PH_ATTACK |-> target_ff == aenv_pkg::ENV_ONE)
      else $error("attack without full-scale target");

endmodule

### design/edge_triggered_adsr_envelope.sv
// channel  | ports     | payload              | dir
// ---------+-----------+----------------------+-----
// request  | req_if.*  | sample_in            | in
// response | rsp_if.*  | envelope, phase      | out
// config   | csr_*     | index, write data    | in
//
// one item per cycle while rsp_if does not stall; an item is taken into the input
// register, and its result is then registered in the result register
// the single multiply-add of the envelope update sets the cycle path
// synchronous reset restores register defaults and clears state to idle
// stall on rsp_if holds the result register; the input register absorbs one
// more item, then req_if.ready drops until the result is taken
module edge_triggered_adsr_envelope #(
   parameter int SAMPLE_WIDTH    = aenv_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEFF_FRAC_BITS = aenv_pkg::COEFF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   aenv_req_if.sink                        req_if,
   aenv_rsp_if.source                      rsp_if,
   input  logic                            csr_we,
   input  logic [aenv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [aenv_pkg::CSR_DATA_W-1:0] csr_wdata
);

   aenv_pkg::cfg_type cfg;

   logic                           in_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [aenv_pkg::ENV_W-1:0]     env_ff;
   aenv_pkg::phase_type            phase_ff;

   logic                       out_free;
   logic                       step_en;
   logic                       req_take;
   logic                       in_valid_in;
   logic [aenv_pkg::ENV_W-1:0] env_new;
   aenv_pkg::phase_type        phase_new;

   aenv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aenv_step #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .sample    (sample_ff),
      .cfg       (cfg),
      .env_new   (env_new),
      .phase_new (phase_new)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_if.ready;
      step_en      = in_valid_ff && out_free;
      req_take     = req_if.valid && req_if.ready;
      in_valid_in  = req_take || (in_valid_ff && !step_en);
      rsp_valid_in = step_en || (rsp_valid_ff && !rsp_if.ready);
   end

   assign req_if.ready    = !in_valid_ff || step_en;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.envelope = env_ff;
   assign rsp_if.phase    = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_ff <= req_if.sample_in;
      end
      if (step_en) begin
         env_ff   <= env_new;
         phase_ff <= phase_new;
      end
   end

   a_step_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("step did not load a result");

   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> env_ff <= aenv_pkg::ENV_ONE)
      else $error("result envelope above one");

   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_if.ready)
      else $error("empty input register refused an item");

   a_stall_blocks_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !step_en)
      else $error("step while result is stalled");

endmodule
